FILE: rtl/core/ggbl_pkg.sv
// Shared constants, codes and types of the geoid grid bilinear lookup.
`default_nettype none

package ggbl_pkg;

    // Grid geometry and interpolation precision
    localparam int unsigned GRID_ROWS = 721;
    localparam int unsigned GRID_COLS = 1441;
    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned GRID_SIZE = GRID_ROWS * GRID_COLS;
    localparam int unsigned ADDR_W    = $clog2(GRID_SIZE);

    // Field widths
    localparam int unsigned IDX_W  = 20;
    localparam int unsigned HGT_W  = 16;
    localparam int unsigned LAT_W  = 19;
    localparam int unsigned LON_W  = 20;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OUT_W  = 32;

    // Coordinates in 1/1024 degree; one grid cell spans 256 units
    localparam int unsigned LAT_LIMIT  = 90 * 1024;
    localparam int unsigned LON_LIMIT  = 180 * 1024;
    localparam int unsigned LON_WRAP   = 360 * 1024;
    localparam int unsigned CELL_SHIFT = 8;
    localparam int unsigned ROW_OFS_W  = 18;
    localparam int unsigned COL_OFS_W  = 19;
    localparam int unsigned ROW_W      = ROW_OFS_W - CELL_SHIFT;
    localparam int unsigned COL_W      = COL_OFS_W - CELL_SHIFT;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_LAT_RANGE = 2'd1,
        STAT_LON_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_ERROR,
        KIND_QUERY
    } kind_t;

    typedef enum logic {
        BK_DISPATCH,
        BK_READ
    } back_state_t;

    // One classified job; a write carries its address in addr0
    typedef struct packed {
        kind_t                 kind;
        status_t               status;
        logic [ADDR_W-1:0]     addr0;
        logic [ADDR_W-1:0]     addr1;
        logic [ADDR_W-1:0]     addr2;
        logic [ADDR_W-1:0]     addr3;
        logic [HGT_W-1:0]      wdata;
        logic [FRAC_BITS-1:0]  fr_r;
        logic [FRAC_BITS-1:0]  fr_c;
    } job_t;

endpackage

`default_nettype wire

FILE: rtl/core/ggbl_front.sv
// Front end: accepts beats, range checks, splits coordinates into cells and addresses.
`default_nettype none

module ggbl_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 operation,
    input  wire logic [ggbl_pkg::IDX_W-1:0]           grid_index,
    input  wire logic [ggbl_pkg::HGT_W-1:0]           grid_value,
    input  wire logic signed [ggbl_pkg::LAT_W-1:0]    latitude,
    input  wire logic signed [ggbl_pkg::LON_W-1:0]    longitude,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output ggbl_pkg::job_t                            push_job
);

    localparam int unsigned FR_UP = (ggbl_pkg::FRAC_BITS >= 8) ? ggbl_pkg::FRAC_BITS - 8 : 0;
    localparam int unsigned FR_DN = (ggbl_pkg::FRAC_BITS < 8) ? 8 - ggbl_pkg::FRAC_BITS : 0;
    localparam logic signed [ggbl_pkg::LAT_W:0] LAT_MAX =
        (ggbl_pkg::LAT_W + 1)'(ggbl_pkg::LAT_LIMIT);
    localparam logic signed [ggbl_pkg::LON_W:0] LON_MAX =
        (ggbl_pkg::LON_W + 1)'(ggbl_pkg::LON_LIMIT);
    localparam logic signed [ggbl_pkg::LON_W:0] LON_WRAP_V =
        (ggbl_pkg::LON_W + 1)'(ggbl_pkg::LON_WRAP);

    typedef struct packed {
        ggbl_pkg::kind_t                      kind;
        ggbl_pkg::status_t                    status;
        logic [ggbl_pkg::ROW_W-1:0]           r0;
        logic [ggbl_pkg::ROW_W-1:0]           r1;
        logic [ggbl_pkg::COL_W-1:0]           c0;
        logic [ggbl_pkg::COL_W-1:0]           c1;
        logic [ggbl_pkg::FRAC_BITS-1:0]       fr_r;
        logic [ggbl_pkg::FRAC_BITS-1:0]       fr_c;
        logic [ggbl_pkg::ADDR_W-1:0]          waddr;
        logic [ggbl_pkg::HGT_W-1:0]           wdata;
    } cell_t;

    logic                               s1_valid_reg, s1_valid_next;
    cell_t                              s1_reg, s1_next;
    logic                               s2_valid_reg, s2_valid_next;
    ggbl_pkg::job_t                     s2_reg, s2_next;
    logic                               s1_ready, s2_ready, keep;
    logic signed [ggbl_pkg::LAT_W:0]    lat_x, row_ofs;
    logic signed [ggbl_pkg::LON_W:0]    lon_x, lon_ofs;
    logic [ggbl_pkg::ROW_W-1:0]         row_raw;
    logic [ggbl_pkg::COL_W-1:0]         col_raw;

    // Stage handshake: a stage loads when empty or when its content moves on
    assign s2_ready   = !s2_valid_reg || push_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign in_ready   = s1_ready;
    assign push_valid = s2_valid_reg;
    assign push_job   = s2_reg;

    // Classify the beat and split the coordinates into cells and fractions
    always_comb
    begin
        lat_x   = (ggbl_pkg::LAT_W + 1)'(latitude);
        lon_x   = (ggbl_pkg::LON_W + 1)'(longitude);
        row_ofs = LAT_MAX - lat_x;
        lon_ofs = (lon_x < 0) ? lon_x + LON_WRAP_V : lon_x;
        row_raw = row_ofs[ggbl_pkg::ROW_OFS_W-1:ggbl_pkg::CELL_SHIFT];
        col_raw = lon_ofs[ggbl_pkg::COL_OFS_W-1:ggbl_pkg::CELL_SHIFT];

        s1_next        = '0;
        s1_next.waddr  = ggbl_pkg::ADDR_W'(grid_index);
        s1_next.wdata  = grid_value;
        keep           = 1'b1;

        if (!operation)
        begin
            s1_next.kind = ggbl_pkg::KIND_WRITE;
            keep         = (32'(grid_index) < ggbl_pkg::GRID_SIZE);
        end
        else if (lat_x > LAT_MAX || lat_x < -LAT_MAX)
        begin
            s1_next.kind   = ggbl_pkg::KIND_ERROR;
            s1_next.status = ggbl_pkg::STAT_LAT_RANGE;
        end
        else if (lon_x > LON_MAX || lon_x < -LON_MAX)
        begin
            s1_next.kind   = ggbl_pkg::KIND_ERROR;
            s1_next.status = ggbl_pkg::STAT_LON_RANGE;
        end
        else
        begin
            s1_next.kind   = ggbl_pkg::KIND_QUERY;
            s1_next.status = ggbl_pkg::STAT_OK;
        end

        // Clamp rows and columns at the grid edge
        s1_next.r0 = (32'(row_raw) > ggbl_pkg::GRID_ROWS - 1) ?
                     ggbl_pkg::ROW_W'(ggbl_pkg::GRID_ROWS - 1) : row_raw;
        s1_next.r1 = (32'(s1_next.r0) == ggbl_pkg::GRID_ROWS - 1) ?
                     s1_next.r0 : s1_next.r0 + 1'b1;
        s1_next.c0 = (32'(col_raw) > ggbl_pkg::GRID_COLS - 1) ?
                     ggbl_pkg::COL_W'(ggbl_pkg::GRID_COLS - 1) : col_raw;
        s1_next.c1 = (32'(s1_next.c0) == ggbl_pkg::GRID_COLS - 1) ?
                     s1_next.c0 : s1_next.c0 + 1'b1;
        s1_next.fr_r = (s1_next.r0 == s1_next.r1) ? '0 :
            ggbl_pkg::FRAC_BITS'((24'(row_ofs[ggbl_pkg::CELL_SHIFT-1:0]) << FR_UP) >> FR_DN);
        s1_next.fr_c = (s1_next.c0 == s1_next.c1) ? '0 :
            ggbl_pkg::FRAC_BITS'((24'(lon_ofs[ggbl_pkg::CELL_SHIFT-1:0]) << FR_UP) >> FR_DN);
    end

    // Form the four corner addresses; a write passes its address in addr0
    always_comb
    begin
        s2_next       = '0;
        s2_next.kind  = s1_reg.kind;
        s2_next.status = s1_reg.status;
        s2_next.wdata = s1_reg.wdata;
        s2_next.fr_r  = s1_reg.fr_r;
        s2_next.fr_c  = s1_reg.fr_c;
        s2_next.addr1 = ggbl_pkg::ADDR_W'(32'(s1_reg.r1) * ggbl_pkg::GRID_COLS + 32'(s1_reg.c0));
        s2_next.addr2 = ggbl_pkg::ADDR_W'(32'(s1_reg.r0) * ggbl_pkg::GRID_COLS + 32'(s1_reg.c1));
        s2_next.addr3 = ggbl_pkg::ADDR_W'(32'(s1_reg.r1) * ggbl_pkg::GRID_COLS + 32'(s1_reg.c1));
        if (s1_reg.kind == ggbl_pkg::KIND_WRITE)
            s2_next.addr0 = s1_reg.waddr;
        else
            s2_next.addr0 = ggbl_pkg::ADDR_W'(32'(s1_reg.r0) * ggbl_pkg::GRID_COLS
                                              + 32'(s1_reg.c0));
    end

    // Advance valid flags; drop writes beyond the grid
    always_comb
    begin
        s1_valid_next = s1_ready ? (in_valid && keep) : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (s1_ready)
            s1_reg <= s1_next;
        if (s2_ready)
            s2_reg <= s2_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/ggbl_queue.sv
// Short job queue that decouples the front end from the back end.
`default_nettype none

module ggbl_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire ggbl_pkg::job_t    push_job,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output ggbl_pkg::job_t         pop_job
);

    ggbl_pkg::job_t                 slot_reg [ggbl_pkg::QUEUE_DEPTH];
    logic [ggbl_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ggbl_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ggbl_pkg::QPTR_W:0]      count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (32'(count_reg) != ggbl_pkg::QUEUE_DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

FILE: rtl/core/ggbl_back.sv
// Back end: grid memory, corner read sequencer, bilinear blend and result register.
`default_nettype none

module ggbl_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire ggbl_pkg::job_t                 pop_job,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ggbl_pkg::STAT_W-1:0]         status,
    output logic [ggbl_pkg::OUT_W-1:0]          height
);

    localparam int unsigned F     = ggbl_pkg::FRAC_BITS;
    localparam int unsigned HW    = ggbl_pkg::HGT_W;
    localparam int unsigned PA_W  = HW + F + 2;
    localparam int unsigned LO_W  = HW + F + 1;
    localparam int unsigned PB_W  = LO_W + F + 2;
    localparam int unsigned V_W   = HW + 2 * F + 1;
    localparam int unsigned Q_SHR = (2 * F >= 16) ? 2 * F - 16 : 0;
    localparam int unsigned Q_SHL = (2 * F < 16) ? 16 - 2 * F : 0;
    localparam int unsigned Q_HALF = (Q_SHR == 0) ? 0 : (1 << (Q_SHR - 1));
    localparam int unsigned QW    = V_W + 1 + Q_SHL;
    localparam logic signed [V_W:0] Q_HALF_V = (V_W + 1)'(Q_HALF);

    // Read tag that travels with each memory read
    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic                           err;
        ggbl_pkg::status_t              status;
        logic [1:0]                     corner;
        logic [F-1:0]                   fr_r;
        logic [F-1:0]                   fr_c;
    } tag_t;

    ggbl_pkg::back_state_t              state_reg, state_next;
    logic [1:0]                         cnt_reg, cnt_next;
    ggbl_pkg::job_t                     work_reg;
    logic                               work_load;
    logic                               adv;
    logic                               mem_we, mem_re;
    logic [ggbl_pkg::ADDR_W-1:0]        mem_addr;
    logic [HW-1:0]                      mem_wdata;
    logic [HW-1:0]                      grid_mem [ggbl_pkg::GRID_SIZE];
    logic [HW-1:0]                      rd_reg;
    tag_t                               tag_issue, tag_reg;
    logic signed [HW-1:0]               h0_reg, h1_reg, h2_reg;

    logic                               a_valid_reg;
    ggbl_pkg::status_t                  a_status_reg;
    logic                               a_err_reg;
    logic signed [LO_W-1:0]             lo_reg, hi_reg;
    logic [F-1:0]                       a_fr_c_reg;

    logic                               b_valid_reg;
    ggbl_pkg::status_t                  b_status_reg;
    logic                               b_err_reg;
    logic signed [V_W-1:0]              v_reg;

    logic                               out_valid_reg;
    logic [ggbl_pkg::STAT_W-1:0]        status_reg;
    logic [ggbl_pkg::OUT_W-1:0]         height_reg;

    logic signed [HW:0]                 d_lo, d_hi;
    logic signed [PA_W-1:0]             p_lo, p_hi, s_lo, s_hi;
    logic signed [LO_W:0]               d_v;
    logic signed [PB_W-1:0]             p_v, s_v;
    logic signed [V_W:0]                v_round, v_shr;
    logic signed [QW-1:0]               q16;

    // Whole back end moves only when the result register can take a beat
    assign adv       = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign height    = height_reg;

    // Next state of the corner read sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ggbl_pkg::BK_DISPATCH:
            begin
                if (adv && pop_valid && pop_job.kind == ggbl_pkg::KIND_QUERY)
                begin
                    state_next = ggbl_pkg::BK_READ;
                    cnt_next   = 2'd1;
                end
            end
            ggbl_pkg::BK_READ:
            begin
                if (adv)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3)
                        state_next = ggbl_pkg::BK_DISPATCH;
                end
            end
            default:
            begin
                state_next = ggbl_pkg::BK_DISPATCH;
                cnt_next   = '0;
            end
        endcase
    end

    // Sequencer outputs: pop, memory port and read tag
    always_comb
    begin
        pop_ready = 1'b0;
        work_load = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = pop_job.addr0;
        mem_wdata = pop_job.wdata;
        tag_issue = '0;
        case (state_reg)
            ggbl_pkg::BK_DISPATCH:
            begin
                if (adv && pop_valid)
                begin
                    pop_ready        = 1'b1;
                    tag_issue.status = pop_job.status;
                    tag_issue.fr_r   = pop_job.fr_r;
                    tag_issue.fr_c   = pop_job.fr_c;
                    case (pop_job.kind)
                        ggbl_pkg::KIND_WRITE:
                            mem_we = 1'b1;
                        ggbl_pkg::KIND_ERROR:
                        begin
                            tag_issue.valid = 1'b1;
                            tag_issue.last  = 1'b1;
                            tag_issue.err   = 1'b1;
                        end
                        ggbl_pkg::KIND_QUERY:
                        begin
                            mem_re          = 1'b1;
                            work_load       = 1'b1;
                            tag_issue.valid = 1'b1;
                        end
                        default:
                            pop_ready = 1'b1;
                    endcase
                end
            end
            ggbl_pkg::BK_READ:
            begin
                if (adv)
                begin
                    mem_re           = 1'b1;
                    tag_issue.valid  = 1'b1;
                    tag_issue.last   = (cnt_reg == 2'd3);
                    tag_issue.corner = cnt_reg;
                    tag_issue.status = work_reg.status;
                    tag_issue.fr_r   = work_reg.fr_r;
                    tag_issue.fr_c   = work_reg.fr_c;
                    case (cnt_reg)
                        2'd1:    mem_addr = work_reg.addr1;
                        2'd2:    mem_addr = work_reg.addr2;
                        2'd3:    mem_addr = work_reg.addr3;
                        default: mem_addr = work_reg.addr0;
                    endcase
                end
            end
            default:
                pop_ready = 1'b0;
        endcase
    end

    // Single-port grid memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_addr] <= mem_wdata;
        else if (mem_re)
            rd_reg <= grid_mem[mem_addr];
    end

    // Row blend of both column pairs
    always_comb
    begin
        d_lo = (HW + 1)'(h1_reg) - (HW + 1)'(h0_reg);
        d_hi = (HW + 1)'($signed(rd_reg)) - (HW + 1)'(h2_reg);
        p_lo = d_lo * $signed({1'b0, tag_reg.fr_r});
        p_hi = d_hi * $signed({1'b0, tag_reg.fr_r});
        s_lo = (PA_W'(h0_reg) <<< F) + p_lo;
        s_hi = (PA_W'(h2_reg) <<< F) + p_hi;
    end

    // Column blend
    always_comb
    begin
        d_v = (LO_W + 1)'(hi_reg) - (LO_W + 1)'(lo_reg);
        p_v = d_v * $signed({1'b0, a_fr_c_reg});
        s_v = (PB_W'(lo_reg) <<< F) + p_v;
    end

    // Bring the blend to 16 fraction bits, ties toward plus infinity
    always_comb
    begin
        v_round = (V_W + 1)'(v_reg) + Q_HALF_V;
        v_shr   = v_round >>> Q_SHR;
        q16     = QW'(v_shr) <<< Q_SHL;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ggbl_pkg::BK_DISPATCH;
            cnt_reg       <= '0;
            tag_reg       <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (adv)
            begin
                tag_reg       <= tag_issue;
                a_valid_reg   <= tag_reg.valid && tag_reg.last;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    // Datapath registers; hold while the result beat waits
    always_ff @(posedge clk)
    begin
        if (work_load)
            work_reg <= pop_job;
        if (adv)
        begin
            if (tag_reg.valid && !tag_reg.err)
            begin
                case (tag_reg.corner)
                    2'd0:    h0_reg <= $signed(rd_reg);
                    2'd1:    h1_reg <= $signed(rd_reg);
                    2'd2:    h2_reg <= $signed(rd_reg);
                    default: h2_reg <= h2_reg;
                endcase
            end
            lo_reg       <= s_lo[LO_W-1:0];
            hi_reg       <= s_hi[LO_W-1:0];
            a_fr_c_reg   <= tag_reg.fr_c;
            a_status_reg <= tag_reg.status;
            a_err_reg    <= tag_reg.err;
            v_reg        <= s_v[V_W-1:0];
            b_status_reg <= a_status_reg;
            b_err_reg    <= a_err_reg;
            status_reg   <= b_status_reg;
            height_reg   <= b_err_reg ? '0 : q16[ggbl_pkg::OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/geoid_grid_bilinear_lookup.sv
// Top level of the geoid grid bilinear lookup.
//
//  channel   dir  tdata                                        tuser
//  s_axis    in   grid_index, grid_value, latitude, longitude  operation
//  m_axis    out  height                                       status
//
// A query holds the single grid memory port for one read per corner; a grid
// write holds it for one write, and a range error does not use it. With an
// idle back end a query's result beat passes the front stages, the queue,
// four corner reads, the row blend, the column blend and the result register.
// Reset clears control only; grid entries are undefined until written. A
// stalled result beat freezes the back end while the front keeps filling the
// queue.
`default_nettype none

module geoid_grid_bilinear_lookup (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // grid_index[19:0], grid_value[35:20], latitude[54:36], longitude[74:55], zero fill
    input  wire logic [79:0]    s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // height[31:0]
    output logic [31:0]         m_axis_tdata,
    // status[1:0]
    output logic [1:0]          m_axis_tuser
);

    logic               push_valid, push_ready;
    ggbl_pkg::job_t     push_job;
    logic               pop_valid, pop_ready;
    ggbl_pkg::job_t     pop_job;

    ggbl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .operation  (s_axis_tuser[0]),
        .grid_index (s_axis_tdata[19:0]),
        .grid_value (s_axis_tdata[35:20]),
        .latitude   (s_axis_tdata[54:36]),
        .longitude  (s_axis_tdata[74:55]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    ggbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    ggbl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (m_axis_tuser),
        .height     (m_axis_tdata)
    );

endmodule

`default_nettype wire
